[hdl/bcpt_pkg.sv]
// package for the bezier control point table
// shared types, codes and fixed widths; no dependencies
package bcpt_pkg;

    localparam int COORD_W  = 16;
    localparam int T_W      = 17;
    localparam int RADIUS_W = 15;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 4;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_CLICK = 2'd1;

    localparam logic [STATUS_W-1:0] ST_CURVE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_LERP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                   op;
        logic [T_W-1:0]             t;
        logic signed [COORD_W-1:0]  wr_x;
        logic signed [COORD_W-1:0]  wr_y;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPEND,
        S_SCAN,
        S_LERP,
        S_DONE
    } state_t;

endpackage

[hdl/bezier_curve_point_table_unit.sv]
// Bezier control point table: load, click with hit test, evaluate by de Casteljau.
// A row of MAX_POINTS cells holds the points; each cell has its own lerp unit and one
// de Casteljau level runs across the row per cycle, and a click compares one stored point
// per cycle. One item is worked on at a time; a finished beat waits in the output
// register while the next item is taken. No clearing pass after reset.
// depends on bcpt_pkg and bcpt_cell
module bezier_curve_point_table_unit #(
    parameter int MAX_POINTS      = 16,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic signed [bcpt_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [bcpt_pkg::COORD_W-1:0]   coord_y,
    input  logic [bcpt_pkg::T_W-1:0]              param_t,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [bcpt_pkg::STATUS_W-1:0]         status,
    output logic [bcpt_pkg::INDEX_W-1:0]          point_index,
    output logic signed [bcpt_pkg::COORD_W-1:0]   curve_x,
    output logic signed [bcpt_pkg::COORD_W-1:0]   curve_y,
    input  logic                                  cfg_we,
    input  logic [bcpt_pkg::RADIUS_W-1:0]         cfg_data
);
    import bcpt_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [31:0] RADIUS_RST = ((32'd1 << COORD_FRAC_BITS) / 20) & 32'h7FFF;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

    state_t state_reg, state_next;
    logic [RADIUS_W-1:0]     radius_reg;
    logic [2*RADIUS_W-1:0]   r2_reg, r2_next;
    logic signed [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [T_W-1:0]          t_reg, t_next;
    logic [CW-1:0]           idx_reg, idx_next, count_reg, count_next;
    logic [STATUS_W-1:0]     rst_reg, rst_next;
    logic [CW-1:0]           ridx_reg, ridx_next;
    logic signed [COORD_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic                    ov_reg, ov_next;
    logic [STATUS_W-1:0]     status_reg;
    logic [INDEX_W-1:0]      index_reg;
    logic signed [COORD_W-1:0] curve_x_reg, curve_y_reg;
    logic [31:0]             ridx_ext;

    cell_ctl_t               ctl;
    logic                    append_we;
    logic signed [COORD_W-1:0] w_x [MAX_POINTS];
    logic signed [COORD_W-1:0] w_y [MAX_POINTS];

    logic signed [COORD_W:0]     dx, dy;
    logic signed [2*COORD_W+1:0] sq_x, sq_y;
    logic [2*COORD_W+2:0]        d2;
    logic                        hit;
    logic                        out_free;

    assign dx   = {w_x[0][COORD_W-1], w_x[0]} - {cx_reg[COORD_W-1], cx_reg};
    assign dy   = {w_y[0][COORD_W-1], w_y[0]} - {cy_reg[COORD_W-1], cy_reg};
    assign sq_x = (2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx);
    assign sq_y = (2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy);
    assign d2   = {1'b0, sq_x} + {1'b0, sq_y};
    assign hit  = d2 < {{(2*COORD_W+3-2*RADIUS_W){1'b0}}, r2_reg};
    assign out_free = !ov_reg || !out_stall;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_POINTS; gi++)
        begin : g_cell
            logic signed [COORD_W-1:0] nb_x, nb_y;
            if (gi == MAX_POINTS - 1)
            begin : g_last
                assign nb_x = w_x[gi];
                assign nb_y = w_y[gi];
            end
            else
            begin : g_mid
                assign nb_x = w_x[gi+1];
                assign nb_y = w_y[gi+1];
            end
            bcpt_cell u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .wr_en (append_we && (count_reg == CW'(gi))),
                .nb_x  (nb_x),
                .nb_y  (nb_y),
                .w_x   (w_x[gi]),
                .w_y   (w_y[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        r2_next    = r2_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        t_next     = t_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        rst_next   = rst_reg;
        ridx_next  = ridx_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        ov_next    = ov_reg && out_stall;
        append_we  = 1'b0;
        ctl.op     = CELL_HOLD;
        ctl.t      = t_reg;
        ctl.wr_x   = cx_reg;
        ctl.wr_y   = cy_reg;
        in_stall   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cx_next  = coord_x;
                    cy_next  = coord_y;
                    t_next   = (param_t > T_ONE) ? T_ONE : param_t;
                    r2_next  = {{RADIUS_W{1'b0}}, radius_reg} * {{RADIUS_W{1'b0}}, radius_reg};
                    idx_next = '0;
                    rx_next  = '0;
                    ry_next  = '0;
                    ridx_next = '0;
                    if (action == ACT_LOAD)
                        state_next = S_APPEND;
                    else if (action == ACT_CLICK)
                    begin
                        ctl.op     = CELL_LOAD;
                        state_next = (count_reg == '0) ? S_APPEND : S_SCAN;
                    end
                    else if (count_reg == '0)
                    begin
                        rst_next   = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ctl.op     = CELL_LOAD;
                        idx_next   = count_reg - CW'(1);
                        state_next = S_LERP;
                    end
                end
            end
            S_APPEND:
            begin
                if (count_reg >= COUNT_MAX)
                    rst_next = ST_FULL;
                else
                begin
                    append_we  = 1'b1;
                    rst_next   = ST_APPENDED;
                    ridx_next  = count_reg;
                    count_next = count_reg + CW'(1);
                end
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                if (idx_reg == count_reg)
                    state_next = S_APPEND;
                else if (hit)
                begin
                    rst_next   = ST_HIT;
                    ridx_next  = idx_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.op   = CELL_SHIFT;
                    idx_next = idx_reg + CW'(1);
                end
            end
            S_LERP:
            begin
                if (idx_reg == '0)
                begin
                    rst_next   = ST_CURVE;
                    rx_next    = w_x[0];
                    ry_next    = w_y[0];
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.op   = CELL_LERP;
                    idx_next = idx_reg - CW'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ridx_ext = 32'(ridx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ov_reg     <= 1'b0;
            radius_reg <= RADIUS_RST[RADIUS_W-1:0];
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
            if (cfg_we)
                radius_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg   <= r2_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        t_reg    <= t_next;
        idx_reg  <= idx_next;
        rst_reg  <= rst_next;
        ridx_reg <= ridx_next;
        rx_reg   <= rx_next;
        ry_reg   <= ry_next;
        if (state_reg == S_DONE && out_free)
        begin
            status_reg  <= rst_reg;
            index_reg   <= ridx_ext[INDEX_W-1:0];
            curve_x_reg <= rx_reg;
            curve_y_reg <= ry_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign status      = status_reg;
    assign point_index = index_reg;
    assign curve_x     = curve_x_reg;
    assign curve_y     = curve_y_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_MAX)
        else $error("point count above table size");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND && count_reg < COUNT_MAX) |=>
        (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not grow the table");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (idx_reg <= count_reg))
        else $error("hit scan ran past the stored points");
`endif

endmodule

[hdl/bcpt_cell.sv]
// one cell of the point chain: stored point, working value and a lerp unit
// depends on bcpt_pkg
module bcpt_cell (
    input  logic                               clk,
    input  bcpt_pkg::cell_ctl_t                ctl,
    input  logic                               wr_en,
    input  logic signed [bcpt_pkg::COORD_W-1:0] nb_x,
    input  logic signed [bcpt_pkg::COORD_W-1:0] nb_y,
    output logic signed [bcpt_pkg::COORD_W-1:0] w_x,
    output logic signed [bcpt_pkg::COORD_W-1:0] w_y
);
    import bcpt_pkg::*;

    logic signed [COORD_W-1:0] pt_x_reg;
    logic signed [COORD_W-1:0] pt_y_reg;
    logic signed [COORD_W-1:0] w_x_reg;
    logic signed [COORD_W-1:0] w_y_reg;
    logic signed [COORD_W-1:0] w_x_next;
    logic signed [COORD_W-1:0] w_y_next;
    logic signed [COORD_W:0]   d_x;
    logic signed [COORD_W:0]   d_y;
    logic signed [T_W:0]       t_s;
    logic signed [COORD_W+T_W+1:0] p_x;
    logic signed [COORD_W+T_W+1:0] p_y;

    assign t_s = signed'({1'b0, ctl.t});
    assign d_x = {nb_x[COORD_W-1], nb_x} - {w_x_reg[COORD_W-1], w_x_reg};
    assign d_y = {nb_y[COORD_W-1], nb_y} - {w_y_reg[COORD_W-1], w_y_reg};
    assign p_x = (COORD_W+T_W+2)'(d_x) * (COORD_W+T_W+2)'(t_s);
    assign p_y = (COORD_W+T_W+2)'(d_y) * (COORD_W+T_W+2)'(t_s);

    always_comb
    begin
        case (ctl.op)
            CELL_LOAD:
            begin
                w_x_next = pt_x_reg;
                w_y_next = pt_y_reg;
            end
            CELL_SHIFT:
            begin
                w_x_next = nb_x;
                w_y_next = nb_y;
            end
            CELL_LERP:
            begin
                w_x_next = w_x_reg + p_x[COORD_W+15:16];
                w_y_next = w_y_reg + p_y[COORD_W+15:16];
            end
            default:
            begin
                w_x_next = w_x_reg;
                w_y_next = w_y_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pt_x_reg <= ctl.wr_x;
            pt_y_reg <= ctl.wr_y;
        end
        w_x_reg <= w_x_next;
        w_y_reg <= w_y_next;
    end

    assign w_x = w_x_reg;
    assign w_y = w_y_reg;

endmodule

[tb/sv/tb_bezier_curve_point_table_unit.sv]
// testbench for bezier_curve_point_table_unit: point loads, clicks with hit test, curve evaluation
// predicts every result beat in place and checks it against the block; depends on bcpt_pkg
`timescale 1ns / 100ps

module tb_bezier_curve_point_table_unit;
    import bcpt_pkg::*;

    localparam int NPTS = 16;
    localparam logic [1:0] ACT_EVAL = 2'd2;
    localparam logic [1:0] ACT_EVAL_ALT = 2'd3;
    localparam int CYCLE_LIMIT = 900000;

    typedef struct packed {
        logic [1:0]                act;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [T_W-1:0]            t;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       st;
        logic [INDEX_W-1:0]        idx;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] action = '0;
    logic signed [COORD_W-1:0] coord_x = '0;
    logic signed [COORD_W-1:0] coord_y = '0;
    logic [T_W-1:0] param_t = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0] point_index;
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic cfg_we = 1'b0;
    logic [RADIUS_W-1:0] cfg_data = '0;

    item_t pending_items[$];
    beat_t expected_beats[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    bit hold_req = 1'b0;
    bit in_held = 1'b0;

    // predictor state
    int tab_x[NPTS];
    int tab_y[NPTS];
    int n_points = 0;
    int radius = 819;

    bezier_curve_point_table_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .coord_x(coord_x), .coord_y(coord_y), .param_t(param_t),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .point_index(point_index), .curve_x(curve_x), .curve_y(curve_y),
        .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int lerp_floor(int a, int b, longint t);
        longint p;
        longint q;
        p = longint'(b - a) * t;
        if (p >= 0)
            q = p >>> 16;
        else
            q = -((-p + 65535) >>> 16);
        return a + int'(q);
    endfunction

    function automatic void queue_item(item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic beat_t store_point(int x, int y);
        beat_t r;
        r = '0;
        if (n_points >= NPTS) begin
            r.st = ST_FULL;
            return r;
        end
        tab_x[n_points] = x;
        tab_y[n_points] = y;
        r.st = ST_APPENDED;
        r.idx = n_points[INDEX_W-1:0];
        n_points++;
        return r;
    endfunction

    function automatic beat_t table_response(item_t it);
        beat_t r;
        longint r2;
        longint dx;
        longint dy;
        longint tt;
        int wx[NPTS];
        int wy[NPTS];
        r = '0;
        if (it.act == ACT_LOAD)
            return store_point(it.x, it.y);
        if (it.act == ACT_CLICK) begin
            r2 = longint'(radius) * radius;
            for (int i = 0; i < n_points; i++) begin
                dx = tab_x[i] - int'(it.x);
                dy = tab_y[i] - int'(it.y);
                if (dx * dx + dy * dy < r2) begin
                    r.st = ST_HIT;
                    r.idx = i[INDEX_W-1:0];
                    return r;
                end
            end
            return store_point(it.x, it.y);
        end
        if (n_points == 0) begin
            r.st = ST_EMPTY;
            return r;
        end
        tt = (it.t > T_ONE) ? 65536 : longint'(it.t);
        for (int i = 0; i < n_points; i++) begin
            wx[i] = tab_x[i];
            wy[i] = tab_y[i];
        end
        for (int lv = n_points - 1; lv > 0; lv--)
            for (int i = 0; i < lv; i++) begin
                wx[i] = lerp_floor(wx[i], wx[i+1], tt);
                wy[i] = lerp_floor(wy[i], wy[i+1], tt);
            end
        r.st = ST_CURVE;
        r.cx = wx[0][COORD_W-1:0];
        r.cy = wy[0][COORD_W-1:0];
        return r;
    endfunction

    // beat still waiting at the last rising edge
    always @(posedge clk)
    begin
        in_held <= in_valid && in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_held)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item_t it;
                    it = pending_items.pop_front();
                    action <= it.act;
                    coord_x <= it.x;
                    coord_y <= it.y;
                    param_t <= it.t;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
            if (hold_req)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles == 1)
                hold_req <= 1'b0;
        end
    end

    // prediction on input beats, check on output beats
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && !in_stall)
            expected_beats = {expected_beats,
                              table_response({action, coord_x, coord_y, param_t})};
        if (rst_n && out_valid && !out_stall)
        begin
            beat_t got;
            beat_t exp_b;
            got = {status, point_index, curve_x, curve_y};
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat st=%0d idx=%0d x=%0d y=%0d",
                             status, point_index, curve_x, curve_y);
            end
            else
            begin
                exp_b = expected_beats.pop_front();
                if (got !== exp_b)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch exp st=%0d idx=%0d x=%0d y=%0d ",
                                  "got st=%0d idx=%0d x=%0d y=%0d"},
                                 exp_b.st, exp_b.idx, exp_b.cx, exp_b.cy,
                                 status, point_index, curve_x, curve_y);
                end
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_bezier_curve_point_table_unit failed");
            $finish;
        end
    end

    function automatic item_t mk(logic [1:0] a, int x, int y, int t);
        item_t it;
        it.act = a;
        it.x = x[COORD_W-1:0];
        it.y = y[COORD_W-1:0];
        it.t = t[T_W-1:0];
        return it;
    endfunction

    function automatic int rnd_coord();
        case ($urandom_range(3))
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(1) ? 32767 : -32768;
            default: return $urandom_range(8000) - 4000;
        endcase
    endfunction

    function automatic int rnd_t();
        case ($urandom_range(5))
            0: return 0;
            1: return 65536;
            2: return $urandom_range(131071);
            default: return $urandom_range(65536);
        endcase
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || expected_beats.size() > 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_radius(int v);
        @(negedge clk);
        cfg_data <= v[RADIUS_W-1:0];
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        radius = v;
    endtask

    // a session: loads, clicks (some near stored points) and evaluations
    task automatic queue_session(int len);
        int px;
        int py;
        int k;
        for (int i = 0; i < len; i++)
        begin
            k = $urandom_range(9);
            if (k < 3)
                queue_item(mk(ACT_LOAD, rnd_coord(), rnd_coord(), $urandom_range(131071)));
            else if (k < 6)
            begin
                px = rnd_coord();
                py = rnd_coord();
                if (n_points > 0 && $urandom_range(1))
                begin
                    px = tab_x[$urandom_range(n_points - 1)] + $urandom_range(600) - 300;
                    py = tab_y[$urandom_range(n_points - 1)] + $urandom_range(600) - 300;
                end
                queue_item(mk(ACT_CLICK, px, py, $urandom_range(131071)));
            end
            else
                queue_item(mk($urandom_range(1) ? ACT_EVAL : ACT_EVAL_ALT,
                              rnd_coord(), rnd_coord(), rnd_t()));
        end
    endtask

    initial
    begin
        int radii[6];
        radii = '{819, 0, 32767, 1, 2000, 300};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty evaluate, single point, extremes, full table
        queue_item(mk(ACT_EVAL, 0, 0, 0));
        queue_item(mk(ACT_EVAL_ALT, 0, 0, 65536));
        queue_item(mk(ACT_LOAD, -32768, 32767, 0));
        queue_item(mk(ACT_EVAL, 0, 0, 100000));
        queue_item(mk(ACT_CLICK, -32768, 32767, 0));
        queue_item(mk(ACT_CLICK, -32768 + 819, 32767, 0));
        queue_item(mk(ACT_CLICK, 32767, -32768, 131071));
        for (int i = 0; i < 14; i++)
            queue_item(mk(ACT_LOAD, i * 4000 - 28000, 20000 - i * 3000, 0));
        queue_item(mk(ACT_LOAD, 1, 1, 0));
        queue_item(mk(ACT_CLICK, 12345, -12345, 0));
        queue_item(mk(ACT_EVAL, 0, 0, 32768));
        queue_item(mk(ACT_EVAL, 0, 0, 1));
        // model the predictor's table alongside for session generation is not needed here
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            // new radius with a fresh-looking table is not possible, so the full table is kept
            write_radius(radii[ph]);
            if (ph < 2)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 84;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_session(280);
            if (ph == 4)
            begin
                hold_cycles = 600;
                hold_req = 1'b1;
            end
            drain();
        end

        if (mismatches == 0)
            $display("tb_bezier_curve_point_table_unit passed");
        else
            $display("tb_bezier_curve_point_table_unit failed");
        $finish;
    end

endmodule

[sim.f]
hdl/bcpt_pkg.sv
hdl/bcpt_cell.sv
hdl/bezier_curve_point_table_unit.sv
tb/sv/tb_bezier_curve_point_table_unit.sv
